### hw/rtl/dllm_pkg.sv
// Shared types and constants for the doubly linked list manager.
// Used by the controller, the datapath and the top level; depends on nothing.
package dllm_pkg;

   localparam int POOL_NODES_DEFAULT = 256;
   localparam int NODE_W             = 8;
   localparam int COUNT_W            = 9;
   localparam int OPCODE_W           = 3;
   localparam int REQ_DATA_W         = 24;
   localparam int REQ_USER_W         = 1;
   localparam int RSP_DATA_W         = 40;
   localparam int RSP_USER_W         = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK    = 3'd0,
      OP_PUSH_FRONT   = 3'd1,
      OP_INSERT_AFTER = 3'd2,
      OP_POP_FRONT    = 3'd3,
      OP_POP_BACK     = 3'd4,
      OP_REMOVE       = 3'd5
   } op_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;   // capture the request and launch the link reads
      logic phase_a;  // first write slot of each link memory
      logic phase_b;  // second write slot of each link memory
      logic commit;   // update head, tail and count and load the response
   } cmd_type;

endpackage

### hw/rtl/dllm_link_ram.sv
// Single link table: one write port and one registered read port.
// Depends on nothing; instantiated twice by the datapath.
module dllm_link_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dllm_ctrl.sv
// Sequencer for the list manager: steps each request through read and two write slots.
// Depends on dllm_pkg for the command struct.
module dllm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dllm_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WR_A = 3'b010,
      ST_WR_B = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_WR_A;
            end
         end
         ST_WR_A: begin
            cmd.phase_a = 1'b1;
            state_in    = ST_WR_B;
         end
         ST_WR_B: begin
            // The second writes repeat harmlessly while the response slot is full.
            cmd.phase_b = 1'b1;
            if (rsp_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hw/rtl/dllm_datapath.sv
// Datapath of the list manager: link memories, head, tail, count and response registers.
// Depends on dllm_pkg and dllm_link_ram.
module dllm_datapath #(
   parameter int POOL_NODES = dllm_pkg::POOL_NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dllm_pkg::cmd_type                cmd,
   input  logic [dllm_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [dllm_pkg::NODE_W-1:0]      req_node_index,
   input  logic [dllm_pkg::NODE_W-1:0]      req_anchor_index,
   input  logic                             req_anchor_valid,
   output logic [dllm_pkg::NODE_W-1:0]      rsp_popped_node,
   output logic                             rsp_popped_valid,
   output logic [dllm_pkg::COUNT_W-1:0]     rsp_list_count,
   output logic [dllm_pkg::NODE_W-1:0]      rsp_head_node,
   output logic                             rsp_head_valid,
   output logic [dllm_pkg::NODE_W-1:0]      rsp_tail_node,
   output logic                             rsp_tail_valid
);

   localparam int PW = $clog2(POOL_NODES + 1);
   localparam int IW = $clog2(POOL_NODES);
   localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

   // Captured request.
   dllm_pkg::op_type op_ff;
   logic [PW-1:0]    node_ff;
   logic [PW-1:0]    anchor_ff;
   logic             anchor_given_ff;
   logic             node_ok_ff;
   logic             anchor_ok_ff;

   // List state.
   logic [PW-1:0]                  first_ff, first_in;
   logic [PW-1:0]                  last_ff, last_in;
   logic [dllm_pkg::COUNT_W-1:0]   count_ff, count_in;

   // Response payload.
   logic [dllm_pkg::NODE_W-1:0]    popped_node_ff;
   logic                           popped_valid_ff;
   logic [dllm_pkg::COUNT_W-1:0]   list_count_ff;
   logic [dllm_pkg::NODE_W-1:0]    head_node_ff;
   logic                           head_valid_ff;
   logic [dllm_pkg::NODE_W-1:0]    tail_node_ff;
   logic                           tail_valid_ff;

   // Memory ports.
   logic [IW-1:0] nxt_rd_addr, prv_rd_addr;
   logic [PW-1:0] rn, rp;
   logic [PW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic          nxt_wv, prv_wv;
   logic          nxt_we, prv_we;

   // Decoded operation.
   logic k_pb, k_pf, k_ins, k_unl, k_popf, k_popb;
   logic popped_in;
   logic [PW-1:0] popped_ptr;

   always_comb begin
      nxt_rd_addr = IW'(req_node_index);
      prv_rd_addr = IW'(req_node_index);
      case (dllm_pkg::op_type'(req_opcode))
         dllm_pkg::OP_INSERT_AFTER: nxt_rd_addr = IW'(req_anchor_index);
         dllm_pkg::OP_POP_FRONT:    nxt_rd_addr = IW'(first_ff);
         dllm_pkg::OP_POP_BACK:     prv_rd_addr = IW'(last_ff);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff           <= dllm_pkg::op_type'(req_opcode);
         node_ff         <= PW'(req_node_index);
         anchor_ff       <= PW'(req_anchor_index);
         anchor_given_ff <= req_anchor_valid;
         node_ok_ff      <= int'(req_node_index) < POOL_NODES;
         anchor_ok_ff    <= int'(req_anchor_index) < POOL_NODES;
      end
   end

   always_comb begin
      k_pb   = 1'b0;
      k_pf   = 1'b0;
      k_ins  = 1'b0;
      k_unl  = 1'b0;
      k_popf = 1'b0;
      k_popb = 1'b0;
      case (op_ff)
         dllm_pkg::OP_PUSH_BACK:    k_pb = node_ok_ff;
         dllm_pkg::OP_PUSH_FRONT:   k_pf = node_ok_ff;
         dllm_pkg::OP_INSERT_AFTER: begin
            // Without an anchor the insert lands at the front.
            k_pf  = node_ok_ff && !anchor_given_ff;
            k_ins = node_ok_ff && anchor_given_ff && anchor_ok_ff;
         end
         dllm_pkg::OP_POP_FRONT:    k_popf = first_ff < NIL;
         dllm_pkg::OP_POP_BACK:     k_popb = last_ff < NIL;
         dllm_pkg::OP_REMOVE:       k_unl = node_ok_ff;
         default: begin
         end
      endcase
   end

   // Write slots. The order within each table follows the order of the list update,
   // so that a later write to the same entry wins.
   always_comb begin
      nxt_wv = 1'b0;
      nxt_wa = node_ff;
      nxt_wd = NIL;
      prv_wv = 1'b0;
      prv_wa = node_ff;
      prv_wd = NIL;
      if (cmd.phase_a) begin
         if (k_pb) begin
            nxt_wv = 1'b1;
            prv_wv = 1'b1;
            prv_wd = last_ff;
         end else if (k_pf) begin
            nxt_wv = 1'b1;
            nxt_wd = first_ff;
            prv_wv = 1'b1;
         end else if (k_ins) begin
            nxt_wv = 1'b1;
            nxt_wd = rn;
            prv_wv = 1'b1;
            prv_wd = anchor_ff;
         end else if (k_unl) begin
            nxt_wv = 1'b1;
            nxt_wa = rp;
            nxt_wd = rn;
            prv_wv = 1'b1;
            prv_wa = rn;
            prv_wd = rp;
         end else if (k_popf) begin
            nxt_wv = 1'b1;
            nxt_wa = first_ff;
            prv_wv = 1'b1;
            prv_wa = rn;
         end else if (k_popb) begin
            nxt_wv = 1'b1;
            nxt_wa = rp;
            prv_wv = 1'b1;
            prv_wa = last_ff;
         end
      end else if (cmd.phase_b) begin
         if (k_pb) begin
            nxt_wv = 1'b1;
            nxt_wa = last_ff;
            nxt_wd = node_ff;
         end else if (k_pf) begin
            prv_wv = 1'b1;
            prv_wa = first_ff;
            prv_wd = node_ff;
         end else if (k_ins) begin
            nxt_wv = 1'b1;
            nxt_wa = anchor_ff;
            nxt_wd = node_ff;
            prv_wv = 1'b1;
            prv_wa = rn;
            prv_wd = node_ff;
         end else if (k_unl) begin
            nxt_wv = 1'b1;
            prv_wv = 1'b1;
         end else if (k_popf) begin
            prv_wv = 1'b1;
            prv_wa = first_ff;
         end else if (k_popb) begin
            nxt_wv = 1'b1;
            nxt_wa = last_ff;
         end
      end
   end

   // A null or out-of-pool target address drops the write.
   assign nxt_we = nxt_wv && (nxt_wa < NIL);
   assign prv_we = prv_wv && (prv_wa < NIL);

   dllm_link_ram #(
      .DEPTH (POOL_NODES),
      .WIDTH (PW)
   ) u_next_ram (
      .clock   (clock),
      .rd_en   (cmd.accept),
      .rd_addr (nxt_rd_addr),
      .rd_data (rn),
      .wr_en   (nxt_we),
      .wr_addr (IW'(nxt_wa)),
      .wr_data (nxt_wd)
   );

   dllm_link_ram #(
      .DEPTH (POOL_NODES),
      .WIDTH (PW)
   ) u_prev_ram (
      .clock   (clock),
      .rd_en   (cmd.accept),
      .rd_addr (prv_rd_addr),
      .rd_data (rp),
      .wr_en   (prv_we),
      .wr_addr (IW'(prv_wa)),
      .wr_data (prv_wd)
   );

   always_comb begin
      first_in   = first_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      popped_in  = 1'b0;
      popped_ptr = first_ff;
      if (cmd.commit) begin
         if (k_pb) begin
            if (last_ff == NIL) begin
               first_in = node_ff;
            end
            last_in  = node_ff;
            count_in = dllm_pkg::COUNT_W'(count_ff + 1'b1);
         end else if (k_pf) begin
            if (first_ff == NIL) begin
               last_in = node_ff;
            end
            first_in = node_ff;
            count_in = dllm_pkg::COUNT_W'(count_ff + 1'b1);
         end else if (k_ins) begin
            if (rn == NIL) begin
               last_in = node_ff;
            end
            count_in = dllm_pkg::COUNT_W'(count_ff + 1'b1);
         end else if (k_unl) begin
            if (rp == NIL) begin
               first_in = rn;
            end
            if (rn == NIL) begin
               last_in = rp;
            end
            count_in = dllm_pkg::COUNT_W'(count_ff - 1'b1);
         end else if (k_popf) begin
            first_in = rn;
            if (rn == NIL) begin
               last_in = NIL;
            end
            count_in  = dllm_pkg::COUNT_W'(count_ff - 1'b1);
            popped_in = 1'b1;
         end else if (k_popb) begin
            last_in = rp;
            if (rp == NIL) begin
               first_in = NIL;
            end
            count_in   = dllm_pkg::COUNT_W'(count_ff - 1'b1);
            popped_in  = 1'b1;
            popped_ptr = last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= NIL;
         last_ff  <= NIL;
         count_ff <= '0;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         popped_node_ff  <= popped_in ? dllm_pkg::NODE_W'(popped_ptr) : '0;
         popped_valid_ff <= popped_in;
         list_count_ff   <= count_in;
         head_node_ff    <= (first_in != NIL) ? dllm_pkg::NODE_W'(first_in) : '0;
         head_valid_ff   <= first_in != NIL;
         tail_node_ff    <= (last_in != NIL) ? dllm_pkg::NODE_W'(last_in) : '0;
         tail_valid_ff   <= last_in != NIL;
      end
   end

   assign rsp_popped_node  = popped_node_ff;
   assign rsp_popped_valid = popped_valid_ff;
   assign rsp_list_count   = list_count_ff;
   assign rsp_head_node    = head_node_ff;
   assign rsp_head_valid   = head_valid_ff;
   assign rsp_tail_node    = tail_node_ff;
   assign rsp_tail_valid   = tail_valid_ff;

endmodule

### hw/rtl/doubly_linked_list_manager.sv
// Doubly linked list manager over a pool of POOL_NODES node indices.
// A request beat is accepted in the idle state and its link reads are registered;
// the two write slots per link memory follow, and the second commits the result to the
// response register. No new request is taken before the commit; a full response register holds the last write slot.
// Reset (synchronous): list empty, count zero, no response pending; link memories
// are not cleared.
module doubly_linked_list_manager #(
   parameter int POOL_NODES = dllm_pkg::POOL_NODES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // opcode [2:0], node_index [10:3], anchor_index [18:11], zero fill [23:19]
   input  logic [dllm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // anchor_valid [0]
   input  logic [dllm_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // popped_node [7:0], list_count [16:8], head_node [24:17], tail_node [32:25],
   // zero fill [39:33]
   output logic [dllm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // popped_valid [0], head_valid [1], tail_valid [2]
   output logic [dllm_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   dllm_pkg::cmd_type              cmd;
   logic [dllm_pkg::NODE_W-1:0]    popped_node;
   logic                           popped_valid;
   logic [dllm_pkg::COUNT_W-1:0]   list_count;
   logic [dllm_pkg::NODE_W-1:0]    head_node;
   logic                           head_valid;
   logic [dllm_pkg::NODE_W-1:0]    tail_node;
   logic                           tail_valid;

   dllm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dllm_datapath #(
      .POOL_NODES (POOL_NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_tdata[2:0]),
      .req_node_index   (req_tdata[10:3]),
      .req_anchor_index (req_tdata[18:11]),
      .req_anchor_valid (req_tuser[0]),
      .rsp_popped_node  (popped_node),
      .rsp_popped_valid (popped_valid),
      .rsp_list_count   (list_count),
      .rsp_head_node    (head_node),
      .rsp_head_valid   (head_valid),
      .rsp_tail_node    (tail_node),
      .rsp_tail_valid   (tail_valid)
   );

   assign rsp_tdata = {7'b0, tail_node, head_node, list_count, popped_node};
   assign rsp_tuser = {tail_valid, head_valid, popped_valid};

endmodule

### sim/tb.sv
// Testbench for doubly_linked_list_manager: drives list operations on the request stream,
// predicts head, tail, count and popped node in a behavioral list, and checks every
// response beat in order. Depends on dllm_pkg and the RTL of the block only.
module tb;

   localparam int          NODES       = 256;
   localparam logic [8:0]  NIL_LINK    = 9'd256;
   localparam logic [2:0]  OP_SPARE_6  = 3'd6;
   localparam logic [2:0]  OP_SPARE_7  = 3'd7;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 10;

   typedef struct packed {
      logic [7:0] popped_node;
      logic       popped_valid;
      logic [8:0] list_count;
      logic [7:0] head_node;
      logic       head_valid;
      logic [7:0] tail_node;
      logic       tail_valid;
   } list_status_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dllm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [dllm_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dllm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [dllm_pkg::RSP_USER_W-1:0] rsp_tuser;

   // Behavioral copy of the list.
   logic [8:0] next_tbl [NODES];
   logic [8:0] prev_tbl [NODES];
   logic [8:0] head_ptr = NIL_LINK;
   logic [8:0] tail_ptr = NIL_LINK;
   logic [8:0] node_total = '0;
   bit         link_written [NODES];

   // Which nodes the well-formed stimulus believes are linked.
   bit         in_list [NODES];
   int         linked_q [$];

   list_status_type pending_status [$];
   list_status_type want_status;
   int              mismatch_count = 0;
   int              rsp_hold_left = 0;
   bit              gaps_on = 1'b1;

   doubly_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (next_tbl[i]) begin
         next_tbl[i] = '0;
         prev_tbl[i] = '0;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void link_at_front(input logic [7:0] n);
      prev_tbl[n] = NIL_LINK;
      next_tbl[n] = head_ptr;
      if (!head_ptr[8]) prev_tbl[head_ptr[7:0]] = {1'b0, n};
      else tail_ptr = {1'b0, n};
      head_ptr = {1'b0, n};
      node_total = node_total + 9'd1;
      link_written[n] = 1'b1;
   endfunction

   // Applies one operation to the behavioral list and returns the status it reports.
   // Misuse (relinking a linked node, unlinking an absent one) is applied as written.
   function automatic list_status_type apply_list_op(input logic [2:0] op,
                                                     input logic [7:0] n,
                                                     input logic [7:0] a, input logic av);
      logic [8:0]      old;
      logic [8:0]      p;
      logic [8:0]      x;
      logic            popped;
      list_status_type s;
      popped = 1'b0;
      old = NIL_LINK;
      case (op)
         dllm_pkg::OP_PUSH_BACK: begin
            prev_tbl[n] = tail_ptr;
            next_tbl[n] = NIL_LINK;
            if (!tail_ptr[8]) next_tbl[tail_ptr[7:0]] = {1'b0, n};
            else head_ptr = {1'b0, n};
            tail_ptr = {1'b0, n};
            node_total = node_total + 9'd1;
            link_written[n] = 1'b1;
         end
         dllm_pkg::OP_PUSH_FRONT: link_at_front(n);
         dllm_pkg::OP_INSERT_AFTER: begin
            if (!av) link_at_front(n);
            else begin
               x = next_tbl[a];
               prev_tbl[n] = {1'b0, a};
               next_tbl[n] = x;
               if (!x[8]) prev_tbl[x[7:0]] = {1'b0, n};
               else tail_ptr = {1'b0, n};
               next_tbl[a] = {1'b0, n};
               node_total = node_total + 9'd1;
               link_written[n] = 1'b1;
            end
         end
         dllm_pkg::OP_POP_FRONT: begin
            if (!head_ptr[8]) begin
               old = head_ptr;
               head_ptr = next_tbl[old[7:0]];
               if (!head_ptr[8]) prev_tbl[head_ptr[7:0]] = NIL_LINK;
               else tail_ptr = NIL_LINK;
               prev_tbl[old[7:0]] = NIL_LINK;
               next_tbl[old[7:0]] = NIL_LINK;
               node_total = node_total - 9'd1;
               popped = 1'b1;
            end
         end
         dllm_pkg::OP_POP_BACK: begin
            if (!tail_ptr[8]) begin
               old = tail_ptr;
               tail_ptr = prev_tbl[old[7:0]];
               if (!tail_ptr[8]) next_tbl[tail_ptr[7:0]] = NIL_LINK;
               else head_ptr = NIL_LINK;
               prev_tbl[old[7:0]] = NIL_LINK;
               next_tbl[old[7:0]] = NIL_LINK;
               node_total = node_total - 9'd1;
               popped = 1'b1;
            end
         end
         dllm_pkg::OP_REMOVE: begin
            p = prev_tbl[n];
            x = next_tbl[n];
            if (!p[8]) next_tbl[p[7:0]] = x;
            else head_ptr = x;
            if (!x[8]) prev_tbl[x[7:0]] = p;
            else tail_ptr = p;
            prev_tbl[n] = NIL_LINK;
            next_tbl[n] = NIL_LINK;
            node_total = node_total - 9'd1;
         end
         default: ;
      endcase
      s.popped_node  = popped ? old[7:0] : 8'd0;
      s.popped_valid = popped;
      s.list_count   = node_total;
      s.head_node    = head_ptr[8] ? 8'd0 : head_ptr[7:0];
      s.head_valid   = !head_ptr[8];
      s.tail_node    = tail_ptr[8] ? 8'd0 : tail_ptr[7:0];
      s.tail_valid   = !tail_ptr[8];
      return s;
   endfunction

   // Sends one request beat and queues the status it should produce.
   task automatic issue_list_op(input logic [2:0] op, input logic [7:0] n, input logic [7:0] a,
                                input logic av, output list_status_type status);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, a, n, op};
      req_tuser  <= av;
      do @(posedge clock); while (!req_tready);
      status = apply_list_op(op, n, a, av);
      pending_status.push_back(status);
   endtask

   function automatic void drop_member(input logic [7:0] n);
      in_list[n] = 1'b0;
      foreach (linked_q[i]) begin
         if (linked_q[i] == int'(n)) begin
            linked_q.delete(i);
            break;
         end
      end
   endfunction

   // One legal operation; grow_pct is the chance of an insert over a removal.
   task automatic random_wellformed(input int grow_pct);
      logic [7:0]      n;
      logic [7:0]      a;
      logic            av;
      int              r;
      int              grow;
      list_status_type got;
      n = 8'($urandom_range(0, 255));
      a = 8'($urandom_range(0, 255));
      av = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      grow = grow_pct;
      if (linked_q.size() == NODES) grow = 0;
      else if (linked_q.size() == 0 && grow < 90) grow = 90;
      if ($urandom_range(0, 99) < grow) begin
         while (in_list[n]) n = 8'($urandom_range(0, 255));
         if (r < 35) issue_list_op(dllm_pkg::OP_PUSH_BACK, n, a, av, got);
         else if (r < 65) issue_list_op(dllm_pkg::OP_PUSH_FRONT, n, a, av, got);
         else if (r < 90 && linked_q.size() > 0)
            issue_list_op(dllm_pkg::OP_INSERT_AFTER, n,
                          8'(linked_q[$urandom_range(0, linked_q.size() - 1)]), 1'b1, got);
         else issue_list_op(dllm_pkg::OP_INSERT_AFTER, n, a, 1'b0, got);
         in_list[n] = 1'b1;
         linked_q.push_back(int'(n));
      end else begin
         if (linked_q.size() > 0 && r >= 66) begin
            n = 8'(linked_q[$urandom_range(0, linked_q.size() - 1)]);
            issue_list_op(dllm_pkg::OP_REMOVE, n, a, av, got);
            drop_member(n);
         end else begin
            issue_list_op((r % 2) ? dllm_pkg::OP_POP_BACK : dllm_pkg::OP_POP_FRONT,
                          n, a, av, got);
            if (got.popped_valid) drop_member(got.popped_node);
         end
      end
   endtask

   task automatic test_directed_edges();
      list_status_type got;
      issue_list_op(dllm_pkg::OP_POP_FRONT, 8'd0, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_POP_BACK, 8'd255, 8'd255, 1'b1, got);
      issue_list_op(OP_SPARE_6, 8'd255, 8'd255, 1'b1, got);
      issue_list_op(OP_SPARE_7, 8'd0, 8'd0, 1'b0, got);
      // Build 7, 255, 1, 0, 128 touching head, tail and middle inserts.
      issue_list_op(dllm_pkg::OP_PUSH_BACK, 8'd0, 8'd255, 1'b1, got);
      issue_list_op(dllm_pkg::OP_PUSH_FRONT, 8'd255, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_INSERT_AFTER, 8'd128, 8'd0, 1'b1, got);
      issue_list_op(dllm_pkg::OP_INSERT_AFTER, 8'd7, 8'd200, 1'b0, got);
      issue_list_op(dllm_pkg::OP_INSERT_AFTER, 8'd1, 8'd255, 1'b1, got);
      issue_list_op(dllm_pkg::OP_REMOVE, 8'd1, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_REMOVE, 8'd7, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_REMOVE, 8'd128, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_POP_FRONT, 8'd0, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_POP_BACK, 8'd0, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_POP_BACK, 8'd0, 8'd0, 1'b0, got);
      // Unlinking an absent node on an empty list wraps the count down; relinking
      // node 3 while it is linked pushes the count back up, and removing it
      // leaves a clean one-node list with a true count.
      issue_list_op(dllm_pkg::OP_REMOVE, 8'd7, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_PUSH_BACK, 8'd3, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_PUSH_BACK, 8'd3, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_PUSH_BACK, 8'd3, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_REMOVE, 8'd3, 8'd0, 1'b0, got);
      issue_list_op(dllm_pkg::OP_POP_FRONT, 8'd0, 8'd0, 1'b0, got);
   endtask

   task automatic test_fill_and_drain();
      while (linked_q.size() < NODES) random_wellformed(100);
      while (linked_q.size() > 0) random_wellformed(0);
      repeat (2) random_wellformed(0);
   endtask

   task automatic test_random_mix();
      for (int seg = 0; seg < 7; seg++) begin
         gaps_on = (seg % 3 != 2);
         repeat (100) random_wellformed((seg % 2) ? 35 : 65);
      end
      gaps_on = 1'b1;
   endtask

   // Any opcode with any fields, except that nothing reads a link entry never written.
   task automatic test_misuse_noise();
      logic [2:0]      op;
      logic [7:0]      n;
      logic [7:0]      a;
      logic            av;
      list_status_type got;
      repeat (120) begin
         op = 3'($urandom_range(0, 7));
         n = 8'($urandom_range(0, 255));
         a = 8'($urandom_range(0, 255));
         av = 1'($urandom_range(0, 1));
         if (op == dllm_pkg::OP_REMOVE)
            while (!link_written[n]) n = 8'($urandom_range(0, 255));
         if (op == dllm_pkg::OP_INSERT_AFTER && av)
            while (!link_written[a]) a = 8'($urandom_range(0, 255));
         issue_list_op(op, n, a, av, got);
      end
   endtask

   task automatic compare_field(input string what, input int expv, input int actv);
      if (expv != actv) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
         mismatch_count++;
      end
   endtask

   // Response checking and random back-pressure on the result stream.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want_status = pending_status.pop_front();
            compare_field("popped_node", int'(want_status.popped_node),
                          int'(rsp_tdata[7:0]));
            compare_field("popped_valid", int'(want_status.popped_valid),
                          int'(rsp_tuser[0]));
            compare_field("list_count", int'(want_status.list_count),
                          int'(rsp_tdata[16:8]));
            compare_field("head_node", int'(want_status.head_node),
                          int'(rsp_tdata[24:17]));
            compare_field("head_valid", int'(want_status.head_valid),
                          int'(rsp_tuser[1]));
            compare_field("tail_node", int'(want_status.tail_node),
                          int'(rsp_tdata[32:25]));
            compare_field("tail_valid", int'(want_status.tail_valid),
                          int'(rsp_tuser[2]));
         end
      end
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_fill_and_drain();
      test_random_mix();
      test_misuse_noise();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
